// ----- rtl/slfc_pkg.sv -----
// Shared types, codes and sizes for the serial link frame codec.
`default_nettype none

package slfc_pkg;

  // Field widths
  localparam int unsigned FrameW   = 11;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgIdxW  = 2;

  // Result queue depth (holds at least the two results of one send)
  localparam int unsigned FifoDepthDef = 4;

  // Box modes
  localparam logic [ModeW-1:0] ModeDisabled = 2'd0;
  localparam logic [ModeW-1:0] ModeCtrlOn   = 2'd1;
  localparam logic [ModeW-1:0] ModeCtrlOff  = 2'd2;
  localparam logic [ModeW-1:0] ModeOffIdy   = 2'd3;

  // Opcodes
  localparam logic OpPoll = 1'b0;
  localparam logic OpSend = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCodeDisable = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCodeCtrlOn  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCodeCtrlOff = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgCodeOffIdy  = 2'd3;

  // Configuration reset values
  localparam logic [FrameW-1:0] RstCodeDisable = 11'd1172;
  localparam logic [FrameW-1:0] RstCodeCtrlOn  = 11'd1174;
  localparam logic [FrameW-1:0] RstCodeCtrlOff = 11'd1175;
  localparam logic [FrameW-1:0] RstCodeOffIdy  = 11'd1173;

  typedef struct packed {
    logic              opcode;
    logic              link_up;
    logic              byte_present;
    logic [ByteW-1:0]  rx_byte;
    logic [FrameW-1:0] send_frame;
  } in_item_t;

  typedef struct packed {
    logic              frame_valid;
    logic [FrameW-1:0] frame_out;
    logic              byte_valid;
    logic [ByteW-1:0]  link_byte;
    logic [ModeW-1:0]  box_mode;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [FrameW-1:0] code_disable;
    logic [FrameW-1:0] code_ctrl_on;
    logic [FrameW-1:0] code_ctrl_off;
    logic [FrameW-1:0] code_off_idy;
  } cfg_t;

  // Results produced by one item, handed to the result queue
  typedef struct packed {
    logic [1:0] num;
    out_item_t  res0;
    out_item_t  res1;
  } push_t;

endpackage

`default_nettype wire

// ----- rtl/serial_link_frame_codec.sv -----
// Top level of the serial link frame codec.
// Usage:
//  - Input channel (in_valid_i/in_ready_o, in_item_i): one item per cycle
//    when ready, a poll or link byte (opcode 0) or frame to send (opcode 1).
//  - Output channel (out_valid_o/out_ready_i, out_item_o): one result per
//    item, two for a live send if not disabled (high, then low byte, last=1).
//  - Configuration channel (cfg_valid_i/cfg_ready_o): writes one of the four
//    box command codes; always ready, write only while the block is idle.
//  - Order: the first result of an item is written to the queue on accept,
//    the low byte of a send directly behind its high byte.
//  - Throughput: one item per cycle while ready; a live send puts two results
//    on the output channel, so the output port sets the rate of send streams.
//  - A four-entry result queue sits between the sides; input stays ready
//    while it has room for two results, so a stalled receiver holds the
//    queue and backs up the input once more than two results are waiting.
//  - Reset: codes return to their defaults, box mode to controller on,
//    seven-bit width, pending high byte and loopback entry empty, queue empty.
`default_nettype none

module serial_link_frame_codec
  import slfc_pkg::*;
#(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_item_t           in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_item_t               out_item_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [FrameW-1:0]  cfg_data_i
);

  cfg_t  cfg;
  push_t push;
  logic  room;
  logic  acc;

  assign in_ready_o = room;
  assign acc        = in_valid_i && room;

  slfc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  slfc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .item_i (in_item_i),
    .cfg_i  (cfg),
    .push_o (push)
  );

  slfc_out_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ----- rtl/slfc_cfg_regs.sv -----
// Command code registers of the serial link frame codec.
`default_nettype none

module slfc_cfg_regs
  import slfc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [FrameW-1:0]  cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Write the addressed code register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_disable  <= RstCodeDisable;
      cfg_q.code_ctrl_on  <= RstCodeCtrlOn;
      cfg_q.code_ctrl_off <= RstCodeCtrlOff;
      cfg_q.code_off_idy  <= RstCodeOffIdy;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgCodeDisable: cfg_q.code_disable  <= cfg_data_i;
        CfgCodeCtrlOn:  cfg_q.code_ctrl_on  <= cfg_data_i;
        CfgCodeCtrlOff: cfg_q.code_ctrl_off <= cfg_data_i;
        CfgCodeOffIdy:  cfg_q.code_off_idy  <= cfg_data_i;
        default:        cfg_q.code_disable  <= cfg_data_i;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/slfc_core.sv -----
// Frame decode, frame split, box mode and loopback state of the codec.
`default_nettype none

module slfc_core
  import slfc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     acc_i,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output push_t         push_o
);

  logic [ByteW-1:0]  high_byte_q, high_byte_d;
  logic              wide_mode_q, wide_mode_d;
  logic [ModeW-1:0]  mode_q, mode_d;
  logic [FrameW-1:0] loop_frame_q, loop_frame_d;
  logic              loop_valid_q, loop_valid_d;

  logic [1:0]        num;
  logic              fv0, bv0, bv1, last0;
  logic [FrameW-1:0] fr0;
  logic [ByteW-1:0]  lb0, lb1;
  logic [FrameW-1:0] rx_frame;
  logic [ByteW-1:0]  b;
  logic [FrameW-1:0] sf;

  assign b  = item_i.rx_byte;
  assign sf = item_i.send_frame;

  // Assemble a received frame from the byte and the pending high byte
  always_comb begin
    if (b[7]) begin
      rx_frame = {high_byte_q[4:1], b[6:0]};
    end else if (b[7:6] == 2'b01) begin
      rx_frame = {high_byte_q[4:0], b[5:0]};
    end else begin
      rx_frame = {3'b000, b};
    end
  end

  // Work out state updates and results of one item
  always_comb begin
    high_byte_d  = high_byte_q;
    wide_mode_d  = wide_mode_q;
    mode_d       = mode_q;
    loop_frame_d = loop_frame_q;
    loop_valid_d = loop_valid_q;
    num   = 2'd1;
    fv0   = 1'b0;
    fr0   = '0;
    bv0   = 1'b0;
    lb0   = '0;
    bv1   = 1'b0;
    lb1   = '0;
    last0 = 1'b1;
    if (item_i.opcode == OpSend) begin
      if (!item_i.link_up || mode_q == ModeDisabled) begin
        // Park the frame in the loopback entry
        loop_frame_d = sf;
        loop_valid_d = 1'b1;
      end else begin
        num   = 2'd2;
        last0 = 1'b0;
        bv0   = 1'b1;
        bv1   = 1'b1;
        if (wide_mode_q) begin
          lb0 = {3'b001, sf[10:7], 1'b0};
          lb1 = {1'b1, sf[6:0]};
        end else begin
          lb0 = {3'b001, sf[10:6]};
          lb1 = {2'b01, sf[5:0]};
        end
        high_byte_d = lb0;
      end
    end else if (!item_i.link_up) begin
      // Return and drop the loopback entry
      fv0          = loop_valid_q;
      fr0          = loop_valid_q ? loop_frame_q : '0;
      loop_valid_d = 1'b0;
      loop_frame_d = '0;
    end else if (item_i.byte_present) begin
      if (b[7:5] == 3'b001) begin
        high_byte_d = b;
      end else begin
        fv0 = 1'b1;
        fr0 = rx_frame;
        if (b[7]) begin
          wide_mode_d = 1'b1;
        end else if (b[7:6] == 2'b01) begin
          wide_mode_d = 1'b0;
        end
        // Box commands: first match wins, echo the byte
        priority if (rx_frame == cfg_i.code_disable) begin
          mode_d = ModeDisabled;
          bv0    = 1'b1;
          lb0    = b;
        end else if (rx_frame == cfg_i.code_ctrl_on) begin
          mode_d = ModeCtrlOn;
          bv0    = 1'b1;
          lb0    = b;
          fv0    = 1'b0;
          fr0    = '0;
        end else if (rx_frame == cfg_i.code_ctrl_off) begin
          mode_d = ModeCtrlOff;
          bv0    = 1'b1;
          lb0    = b;
          fv0    = 1'b0;
          fr0    = '0;
        end else if (rx_frame == cfg_i.code_off_idy) begin
          mode_d = ModeOffIdy;
          bv0    = 1'b1;
          lb0    = b;
          fv0    = 1'b0;
          fr0    = '0;
        end else begin
          mode_d = mode_q;
        end
      end
    end
  end

  // Hand results to the queue
  always_comb begin
    push_o.num              = acc_i ? num : 2'd0;
    push_o.res0.frame_valid = fv0;
    push_o.res0.frame_out   = fr0;
    push_o.res0.byte_valid  = bv0;
    push_o.res0.link_byte   = lb0;
    push_o.res0.box_mode    = mode_d;
    push_o.res0.last        = last0;
    push_o.res1.frame_valid = 1'b0;
    push_o.res1.frame_out   = '0;
    push_o.res1.byte_valid  = bv1;
    push_o.res1.link_byte   = lb1;
    push_o.res1.box_mode    = mode_d;
    push_o.res1.last        = 1'b1;
  end

  // Advance state on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_byte_q  <= '0;
      wide_mode_q  <= 1'b0;
      mode_q       <= ModeCtrlOn;
      loop_frame_q <= '0;
      loop_valid_q <= 1'b0;
    end else if (acc_i) begin
      high_byte_q  <= high_byte_d;
      wide_mode_q  <= wide_mode_d;
      mode_q       <= mode_d;
      loop_frame_q <= loop_frame_d;
      loop_valid_q <= loop_valid_d;
    end
  end

`ifndef SYNTH
  // A live send leaves its high byte as the pending high byte
  a_send_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && push_o.num == 2'd2) |=> high_byte_q == $past(push_o.res0.link_byte))
    else $error("high byte not kept after send");
  // A loopback poll empties the entry
  a_poll_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && item_i.opcode == OpPoll && !item_i.link_up) |=> !loop_valid_q)
    else $error("loopback entry not emptied");
  // Disabled box never splits a frame onto the link
  a_dis_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && mode_q == ModeDisabled && item_i.opcode == OpSend) |-> push_o.num == 2'd1)
    else $error("send on disabled box went to link");
`endif

endmodule

`default_nettype wire

// ----- rtl/slfc_out_fifo.sv -----
// Result queue of the codec: takes up to two results per cycle, gives one when ready.
`default_nettype none

module slfc_out_fifo
  import slfc_pkg::*;
#(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output out_item_t  out_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] RoomMax = CntW'(Depth - 2);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  out_item_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, wr_nx, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == LastPtr) ? '0 : p + 1'b1;
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_q];
  assign room_o      = (cnt_q <= RoomMax);
  assign wr_nx       = ptr_inc(wr_q);

  // Move pointers and fill count
  always_comb begin
    wr_d = wr_q;
    if (push_i.num == 2'd1) begin
      wr_d = wr_nx;
    end else if (push_i.num == 2'd2) begin
      wr_d = ptr_inc(wr_nx);
    end
    rd_d  = pop ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.num) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store pushed results
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_nx] <= push_i.res1;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> (cnt_q + CntW'(push_i.num)) <= CntW'(Depth))
    else $error("result queue overflow");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue count out of range");
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.num == 2'd0) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("result queue count lost a pop");
`endif

endmodule

`default_nettype wire

// ----- test/slfc_checker.sv -----
// Checker for the serial link frame codec: predicts every result and compares it.
`timescale 1ns / 1ps

module slfc_checker
  import slfc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_item_t            in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_item_t           out_item_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [FrameW-1:0]   cfg_data_i,
  output int                  pending_o,
  output int                  fail_count_o
);

  // Shadow copy of the command codes and the codec state
  logic [FrameW-1:0] cmd_codes [4];
  logic [ByteW-1:0]  high_byte;
  logic              wide_mode;
  logic [ModeW-1:0]  box_mode;
  logic [FrameW-1:0] loop_frame;
  logic              loop_full;

  out_item_t link_results_q [$];
  out_item_t want;
  int        mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic compare_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Decode or encode one item and queue the results it causes
  task automatic bridge_item(input in_item_t it);
    out_item_t         r0;
    out_item_t         r1;
    logic [FrameW-1:0] frame;
    logic [ByteW-1:0]  hi;
    logic [ByteW-1:0]  lo;
    logic              fv;
    logic              echo;
    r0 = '0;
    r1 = '0;
    r0.last = 1'b1;
    if (it.opcode == OpSend) begin
      if (!it.link_up || box_mode == ModeDisabled) begin
        // park the frame in the loopback entry
        loop_frame = it.send_frame;
        loop_full  = 1'b1;
        r0.box_mode = box_mode;
        link_results_q.push_back(r0);
      end else begin
        if (wide_mode) begin
          hi = {3'b001, it.send_frame[10:7], 1'b0};
          lo = {1'b1, it.send_frame[6:0]};
        end else begin
          hi = {3'b001, it.send_frame[10:6]};
          lo = {2'b01, it.send_frame[5:0]};
        end
        high_byte = hi;
        r0.byte_valid = 1'b1;
        r0.link_byte  = hi;
        r0.box_mode   = box_mode;
        r0.last       = 1'b0;
        r1.byte_valid = 1'b1;
        r1.link_byte  = lo;
        r1.box_mode   = box_mode;
        r1.last       = 1'b1;
        link_results_q.push_back(r0);
        link_results_q.push_back(r1);
      end
    end else if (!it.link_up) begin
      // return and empty the loopback entry
      r0.frame_valid = loop_full;
      r0.frame_out   = loop_full ? loop_frame : '0;
      r0.box_mode    = box_mode;
      loop_full  = 1'b0;
      loop_frame = '0;
      link_results_q.push_back(r0);
    end else if (!it.byte_present) begin
      r0.box_mode = box_mode;
      link_results_q.push_back(r0);
    end else if (it.rx_byte[7:5] == 3'b001) begin
      high_byte   = it.rx_byte;
      r0.box_mode = box_mode;
      link_results_q.push_back(r0);
    end else begin
      // complete a frame, then match it against the box commands
      fv   = 1'b1;
      echo = 1'b0;
      if (it.rx_byte[7]) begin
        wide_mode = 1'b1;
        frame = {high_byte[4:1], it.rx_byte[6:0]};
      end else if (it.rx_byte[7:6] == 2'b01) begin
        wide_mode = 1'b0;
        frame = {high_byte[4:0], it.rx_byte[5:0]};
      end else begin
        frame = {3'b000, it.rx_byte};
      end
      if (frame == cmd_codes[CfgCodeDisable]) begin
        box_mode = ModeDisabled;
        echo = 1'b1;
      end else if (frame == cmd_codes[CfgCodeCtrlOn]) begin
        box_mode = ModeCtrlOn;
        echo = 1'b1;
        fv = 1'b0;
      end else if (frame == cmd_codes[CfgCodeCtrlOff]) begin
        box_mode = ModeCtrlOff;
        echo = 1'b1;
        fv = 1'b0;
      end else if (frame == cmd_codes[CfgCodeOffIdy]) begin
        box_mode = ModeOffIdy;
        echo = 1'b1;
        fv = 1'b0;
      end
      r0.frame_valid = fv;
      r0.frame_out   = fv ? frame : '0;
      r0.byte_valid  = echo;
      r0.link_byte   = echo ? it.rx_byte : '0;
      r0.box_mode    = box_mode;
      link_results_q.push_back(r0);
    end
  endtask

  // Watch the three channels: check results, track codes, predict items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_codes[CfgCodeDisable] = RstCodeDisable;
      cmd_codes[CfgCodeCtrlOn]  = RstCodeCtrlOn;
      cmd_codes[CfgCodeCtrlOff] = RstCodeCtrlOff;
      cmd_codes[CfgCodeOffIdy]  = RstCodeOffIdy;
      high_byte  = '0;
      wide_mode  = 1'b0;
      box_mode   = ModeCtrlOn;
      loop_frame = '0;
      loop_full  = 1'b0;
      link_results_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (link_results_q.size() == 0) begin
          $error("result item with nothing expected: %p", out_item_i);
          mismatches++;
        end else begin
          want = link_results_q.pop_front();
          compare_field("frame_valid", 32'(want.frame_valid), 32'(out_item_i.frame_valid));
          compare_field("frame_out", 32'(want.frame_out), 32'(out_item_i.frame_out));
          compare_field("byte_valid", 32'(want.byte_valid), 32'(out_item_i.byte_valid));
          compare_field("link_byte", 32'(want.link_byte), 32'(out_item_i.link_byte));
          compare_field("box_mode", 32'(want.box_mode), 32'(out_item_i.box_mode));
          compare_field("last", 32'(want.last), 32'(out_item_i.last));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        cmd_codes[cfg_index_i] = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        bridge_item(in_item_i);
      end
    end
    pending_o <= link_results_q.size();
  end

endmodule

// ----- test/tb_serial_link_frame_codec.sv -----
// Testbench top for the serial link frame codec: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_serial_link_frame_codec;
  import slfc_pkg::*;

  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 5000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_item;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [FrameW-1:0] cfg_data;
  int                pending;
  int                fail_count;

  // Stimulus knobs and the codes currently programmed
  logic              tx_gaps;
  logic              rx_gaps;
  logic              rx_hold_req;
  logic [FrameW-1:0] cur_codes [4];

  always #5 clk = ~clk;

  serial_link_frame_codec i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  slfc_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic in_item_t poll_item(input logic link, input logic present,
                                         input logic [ByteW-1:0] b);
    in_item_t it;
    it.opcode       = OpPoll;
    it.link_up      = link;
    it.byte_present = present;
    it.rx_byte      = b;
    it.send_frame   = FrameW'($urandom_range(0, 2047));
    return it;
  endfunction

  function automatic in_item_t send_item(input logic link, input logic [FrameW-1:0] f);
    in_item_t it;
    it.opcode       = OpSend;
    it.link_up      = link;
    it.byte_present = 1'($urandom_range(0, 1));
    it.rx_byte      = ByteW'($urandom_range(0, 255));
    it.send_frame   = f;
    return it;
  endfunction

  // Offer one item, hold it until accepted, then maybe idle
  task automatic put_item(input in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  // Send a frame as a high byte and a low byte in the given width
  task automatic put_frame(input logic [FrameW-1:0] f, input logic wide);
    logic [ByteW-1:0] hi;
    logic [ByteW-1:0] lo;
    logic             pad;
    pad = 1'($urandom_range(0, 1));
    if (wide) begin
      hi = {3'b001, f[10:7], pad};
      lo = {1'b1, f[6:0]};
    end else begin
      hi = {3'b001, f[10:6]};
      lo = {2'b01, f[5:0]};
    end
    put_item(poll_item(1'b1, 1'b1, hi));
    put_item(poll_item(1'b1, 1'b1, lo));
  endtask

  // Stop offering and wait until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Program all four command codes while the block is idle
  task automatic set_codes(input logic [FrameW-1:0] c_dis, input logic [FrameW-1:0] c_on,
                           input logic [FrameW-1:0] c_off, input logic [FrameW-1:0] c_idy);
    logic [FrameW-1:0] vals [4];
    vals[CfgCodeDisable] = c_dis;
    vals[CfgCodeCtrlOn]  = c_on;
    vals[CfgCodeCtrlOff] = c_off;
    vals[CfgCodeOffIdy]  = c_idy;
    drain();
    for (int i = int'(CfgCodeDisable); i <= int'(CfgCodeOffIdy); i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CfgIdxW'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      cur_codes[i] = vals[i];
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed byte pairs, plus sends, polls and stray bytes
  task automatic random_burst(input int n);
    int                count;
    int                pick;
    logic [FrameW-1:0] f;
    count = 0;
    while (count < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        if ($urandom_range(0, 3) == 0) begin
          f = cur_codes[CfgIdxW'($urandom_range(CfgCodeDisable, CfgCodeOffIdy))];
        end else begin
          f = FrameW'($urandom_range(0, 2047));
        end
        put_frame(f, 1'($urandom_range(0, 1)));
        count += 2;
      end else begin
        if (pick < 60) begin
          put_item(send_item($urandom_range(0, 5) != 0, FrameW'($urandom_range(0, 2047))));
        end else if (pick < 68) begin
          put_item(poll_item(1'b0, 1'($urandom_range(0, 1)), ByteW'($urandom_range(0, 255))));
        end else if (pick < 76) begin
          put_item(poll_item(1'b1, 1'b0, ByteW'($urandom_range(0, 255))));
        end else begin
          put_item(poll_item(1'b1, 1'b1, ByteW'($urandom_range(0, 255))));
        end
        count++;
      end
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        out_ready <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Main sequence
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CfgCodeDisable;
    cfg_data    = '0;
    tx_gaps     = 1'b1;
    rx_gaps     = 1'b1;
    rx_hold_req = 1'b0;
    cur_codes[CfgCodeDisable] = RstCodeDisable;
    cur_codes[CfgCodeCtrlOn]  = RstCodeCtrlOn;
    cur_codes[CfgCodeCtrlOff] = RstCodeCtrlOff;
    cur_codes[CfgCodeOffIdy]  = RstCodeOffIdy;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle link, empty loopback
    put_item(poll_item(1'b1, 1'b0, 8'hA5));
    put_item(poll_item(1'b0, 1'b1, 8'hFF));
    // fill, overwrite, return and empty the loopback
    put_item(send_item(1'b0, 11'h7FF));
    put_item(send_item(1'b0, 11'h000));
    put_item(poll_item(1'b0, 1'b0, 8'h00));
    put_item(poll_item(1'b0, 1'b0, 8'h00));
    // live sends in seven-bit mode
    put_item(send_item(1'b1, 11'h7FF));
    put_item(send_item(1'b1, 11'h000));
    // eight-bit frame switches to wide mode, then a wide send
    put_frame(11'h7FF, 1'b1);
    put_item(send_item(1'b1, 11'h7FF));
    // seven-bit frame switches back
    put_frame(11'h000, 1'b0);
    // bytes that are whole frames
    put_item(poll_item(1'b1, 1'b1, 8'h00));
    put_item(poll_item(1'b1, 1'b1, 8'h1F));
    // disable: delivered and echoed, then sends loop back
    put_frame(cur_codes[CfgCodeDisable], 1'b0);
    put_item(send_item(1'b1, 11'h555));
    put_item(poll_item(1'b0, 1'b0, 8'h00));
    // remaining box commands
    put_frame(cur_codes[CfgCodeCtrlOn], 1'b1);
    put_frame(cur_codes[CfgCodeCtrlOff], 1'b0);
    put_frame(cur_codes[CfgCodeOffIdy], 1'b0);

    random_burst(300);

    // long receiver hold-off while the sender keeps offering
    rx_hold_req = 1'b1;
    tx_gaps = 1'b0;
    random_burst(40);
    tx_gaps = 1'b1;

    // extreme codes
    set_codes(11'd0, 11'd2047, 11'd1, 11'd2046);
    random_burst(350);

    // all codes equal: disable wins
    set_codes(cur_codes[CfgCodeCtrlOn] ^ 11'h2AA, cur_codes[CfgCodeCtrlOn] ^ 11'h2AA,
              cur_codes[CfgCodeCtrlOn] ^ 11'h2AA, cur_codes[CfgCodeCtrlOn] ^ 11'h2AA);
    random_burst(300);

    // random codes, no idling on either side
    rx_gaps = 1'b0;
    tx_gaps = 1'b0;
    set_codes(FrameW'($urandom_range(0, 2047)), FrameW'($urandom_range(0, 2047)),
              FrameW'($urandom_range(0, 2047)), FrameW'($urandom_range(0, 2047)));
    random_burst(300);
    rx_gaps = 1'b1;
    tx_gaps = 1'b1;

    // codes reachable by a single whole-frame byte
    set_codes(FrameW'($urandom_range(0, 31)), FrameW'($urandom_range(0, 31)),
              FrameW'($urandom_range(0, 31)), FrameW'($urandom_range(0, 31)));
    random_burst(350);

    // extremes the other way round
    set_codes(11'd2047, 11'd0, 11'd2046, 11'd1);
    random_burst(300);

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
